>>> design/ordered_list_insert_erase_macros.svh
// assertion macros used by the ordered list design file
`ifndef ORDERED_LIST_INSERT_ERASE_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_MACROS_SVH

`ifndef NO_ASSERTIONS

// a holds in a cycle -> b holds in that same cycle
`define OLIE_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("olie assertion failed: same-cycle implication");

// a holds in a cycle -> b holds in the following cycle
`define OLIE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("olie assertion failed: next-cycle implication");

`else

`define OLIE_ASSERT_SAME(label, clk, rst_n, a, b)
`define OLIE_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

>>> design/olie_pkg.sv
package olie_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int ECNT_W   = 7;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_ROTATE
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                 op;
        logic [POS_W-1:0]         pos;
        logic [IDX_W-1:0]         last_idx;
        logic signed [VAL_W-1:0]  value;
    } cell_ctrl_t;

endpackage

>>> design/ordered_list_insert_erase.sv
// Ordered list of up to 64 signed 32-bit values held in a chain of cells,
// one cell per place. A transaction on the slave side carries the command in
// s_tuser (0 insert, 1 erase, 2 dump, 3 no operation) and position and value
// in s_tdata. Insert and erase shift every later entry by one place all at
// once, so such a transaction gives one result. A dump of n entries gives n
// results, one per cycle while the master side takes them, by rotating the
// held run through the head cell; the slave side is held off until the last
// of them is in the output register. Every result carries a status in
// m_tuser (0 ok, 1 full, 2 bad position, 3 dump of an empty list), the entry
// count after the command and the dumped entry in m_tdata, and m_tlast on the
// final result of the command. A full list and an out-of-range position are
// rejected and leave the list unchanged. Entries need no clearing after
// reset: only places below the count are read.
`include "ordered_list_insert_erase_macros.svh"

module ordered_list_insert_erase (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [olie_pkg::DATA_W-1:0]     s_tdata,   // position[6:0], value[38:7], zero pad
    input  logic [olie_pkg::CMD_W-1:0]      s_tuser,   // command[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [olie_pkg::DATA_W-1:0]     m_tdata,   // entry_count[6:0], entry_value[38:7], zero pad
    output logic [olie_pkg::STAT_W-1:0]     m_tuser,   // status[1:0]
    output logic                            m_tlast
);
    import olie_pkg::*;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   dump_idx_reg;
    logic [IDX_W-1:0]   dump_idx_next;

    // output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STAT_W-1:0]       out_status_reg;
    logic [STAT_W-1:0]       out_status_next;
    logic [ECNT_W-1:0]       out_count_reg;
    logic [ECNT_W-1:0]       out_count_next;
    logic signed [VAL_W-1:0] out_value_reg;
    logic signed [VAL_W-1:0] out_value_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic                    accept;
    logic                    slot_free;
    logic                    load_out;
    cmd_t                    cmd;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] in_value;
    logic [CNT_W-1:0]        cnt_minus1;
    logic [IDX_W-1:0]        last_idx;
    logic                    dump_last;
    logic                    is_full;
    logic                    dump_start;
    cell_ctrl_t              ctrl;

    logic signed [VAL_W-1:0] cell_q [CAPACITY];

    // unpack the slave-side transaction
    assign cmd      = cmd_t'(s_tuser);
    assign pos      = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W +: VAL_W];

    // the output register frees when empty or when its result is taken
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    assign cnt_minus1 = count_reg - CNT_W'(1);
    assign last_idx   = cnt_minus1[IDX_W-1:0];
    assign dump_last  = (dump_idx_reg == last_idx);
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign dump_start = accept && (cmd == CMD_DUMP) && (count_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dump_start)
                    state_next = ST_DUMP;
            end
            ST_DUMP:
            begin
                if (slot_free && dump_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: cell control, count and result
    always_comb
    begin
        ctrl.op         = CELL_HOLD;
        ctrl.pos        = pos;
        ctrl.last_idx   = last_idx;
        ctrl.value      = in_value;
        count_next      = count_reg;
        dump_idx_next   = dump_idx_reg;
        load_out        = 1'b0;
        out_status_next = STAT_OK;
        out_value_next  = '0;
        out_last_next   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            if (is_full)
                                out_status_next = STAT_FULL;
                            else if (pos > POS_W'(count_reg))
                                out_status_next = STAT_BADPOS;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (pos >= POS_W'(count_reg))
                                out_status_next = STAT_BADPOS;
                            else
                            begin
                                ctrl.op    = CELL_ERASE;
                                count_next = cnt_minus1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                // results come from the dump state
                                load_out      = 1'b0;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            out_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_value_next = cell_q[0];
                    out_last_next  = dump_last;
                    ctrl.op        = CELL_ROTATE;
                    dump_idx_next  = dump_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
        out_count_next = ECNT_W'(count_next);
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // chain of cells, each fed by its neighbours and the head
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_q[g+1];
        end

        olie_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(g)),
            .ctrl      (ctrl),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_q[0]),
            .entry     (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(DATA_W - ECNT_W - VAL_W){1'b0}}, out_value_reg, out_count_reg};

    // checks
    `OLIE_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `OLIE_ASSERT_SAME(a_no_take_in_dump, clk, rst_n, state_reg == ST_DUMP, !s_tready)
    `OLIE_ASSERT_NEXT(a_dump_ends, clk, rst_n,
        (state_reg == ST_DUMP) && slot_free && dump_last, state_reg == ST_IDLE)
    `OLIE_ASSERT_NEXT(a_count_steady_in_dump, clk, rst_n,
        state_reg == ST_DUMP, count_reg == $past(count_reg))

endmodule

>>> design/olie_cell.sv
module olie_cell (
    input  logic                               clk,
    input  logic [olie_pkg::IDX_W-1:0]         idx,
    input  olie_pkg::cell_ctrl_t               ctrl,
    input  logic signed [olie_pkg::VAL_W-1:0]  left_val,
    input  logic signed [olie_pkg::VAL_W-1:0]  right_val,
    input  logic signed [olie_pkg::VAL_W-1:0]  head_val,
    output logic signed [olie_pkg::VAL_W-1:0]  entry
);
    import olie_pkg::*;

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic [POS_W-1:0]        my_pos;

    assign my_pos = POS_W'(idx);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (my_pos > ctrl.pos)
                    entry_next = left_val;
                else if (my_pos == ctrl.pos)
                    entry_next = ctrl.value;
            end
            CELL_ERASE:
            begin
                if (my_pos >= ctrl.pos)
                    entry_next = right_val;
            end
            CELL_ROTATE:
            begin
                // the held run turns one place towards the head
                if (idx < ctrl.last_idx)
                    entry_next = right_val;
                else if (idx == ctrl.last_idx)
                    entry_next = head_val;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> sim/tb_top.sv
module tb_top;
    import olie_pkg::*;

    // no transaction on either side for this long means the block has hung
    localparam int IDLE_LIMIT   = 2000;
    // cycles allowed after the last expected result for stray results to show
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [ECNT_W-1:0]       entry_count;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last;
    } list_result_t;

    // mirror of the list plus the queue of results still owed by the block
    class list_scoreboard;
        logic signed [VAL_W-1:0] held [CAPACITY];
        int unsigned             held_count;
        list_result_t            pending [$];
        int                      errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        function void push_result(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] v, logic fin);
            list_result_t r;
            r.status      = st;
            r.entry_count = ECNT_W'(held_count);
            r.entry_value = v;
            r.last        = fin;
            pending.push_back(r);
        endfunction

        // update the mirror for one accepted command and queue what it owes
        function void note_command(cmd_t cmd, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            int                i;
            logic [STAT_W-1:0] st;
            st = STAT_OK;
            case (cmd)
                CMD_INSERT:
                begin
                    // a full list is refused before the position is looked at
                    if (held_count >= CAPACITY)
                        st = STAT_FULL;
                    else if (pos > held_count)
                        st = STAT_BADPOS;
                    else
                    begin
                        for (i = int'(held_count); i > int'(pos); i--)
                            held[i] = held[i - 1];
                        held[pos] = val;
                        held_count++;
                    end
                    push_result(st, '0, 1'b1);
                end
                CMD_ERASE:
                begin
                    if (pos >= held_count)
                        st = STAT_BADPOS;
                    else
                    begin
                        for (i = int'(pos) + 1; i < int'(held_count); i++)
                            held[i - 1] = held[i];
                        held_count--;
                    end
                    push_result(st, '0, 1'b1);
                end
                CMD_DUMP:
                begin
                    if (held_count == 0)
                        push_result(STAT_EMPTY, '0, 1'b1);
                    else
                        for (i = 0; i < int'(held_count); i++)
                            push_result(STAT_OK, held[i], i == int'(held_count) - 1);
                end
                default:
                    push_result(STAT_OK, '0, 1'b1);
            endcase
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: status %0d count %0d value %0d last %0d",
                             got.status, got.entry_count, got.entry_value, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.entry_count !== want.entry_count ||
                got.entry_value !== want.entry_value || got.last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: expected status %0d count %0d value %0d last %0d, %s",
                             want.status, want.entry_count, want.entry_value, want.last,
                             $sformatf("got status %0d count %0d value %0d last %0d",
                                       got.status, got.entry_count, got.entry_value,
                                       got.last));
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [DATA_W-1:0]       s_tdata;   // position[6:0], value[38:7], zero pad
    logic [CMD_W-1:0]        s_tuser;   // command[1:0]
    logic                    m_tvalid;
    logic                    m_tready;
    logic [DATA_W-1:0]       m_tdata;   // entry_count[6:0], entry_value[38:7], zero pad
    logic [STAT_W-1:0]       m_tuser;   // status[1:0]
    logic                    m_tlast;

    list_scoreboard board;
    bit             send_burst;
    bit             recv_burst;

    ordered_list_insert_erase dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // values lean towards the extremes now and then
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9, 0))
            0:       return {1'b0, {(VAL_W - 1){1'b1}}};
            1:       return {1'b1, {(VAL_W - 1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // one slave-side transaction; returns at the rising edge that takes it
    task automatic send_command(cmd_t cmd, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] val);
        int gap;
        bit taken;
        gap = send_burst ? 0 : $urandom_range(3, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {1'b0, val, pos};
        taken    = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = s_tready;
        end
        board.note_command(cmd, pos, val);
    endtask

    // weighted pick of one command, positions mostly legal for the current count
    task automatic random_item(int insert_w, int erase_w, int dump_w);
        int          roll;
        int unsigned cnt;
        cnt  = board.held_count;
        roll = $urandom_range(99, 0);
        if (roll < insert_w)
            send_command(CMD_INSERT, POS_W'($urandom_range(cnt, 0)), pick_value());
        else if (roll < insert_w + erase_w)
            send_command(CMD_ERASE, POS_W'(cnt == 0 ? 0 : $urandom_range(cnt - 1, 0)),
                         pick_value());
        else if (roll < insert_w + erase_w + dump_w)
            send_command(CMD_DUMP, POS_W'($urandom_range(127, 0)), pick_value());
        else
            send_command(cmd_t'($urandom_range(3, 0)), POS_W'($urandom_range(127, 0)),
                         pick_value());
        if ($urandom_range(29, 0) == 0)
            send_burst = !send_burst;
    endtask

    // master side: random stall before each result, then check it
    initial
    begin
        int           stall;
        bit           taken;
        list_result_t got;
        @(posedge rst_n);
        forever
        begin
            stall = recv_burst ? 0 : $urandom_range(3, 0);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            taken    = 1'b0;
            while (!taken)
            begin
                @(posedge clk);
                taken = m_tvalid;
            end
            got.status      = m_tuser;
            got.entry_count = m_tdata[ECNT_W-1:0];
            got.entry_value = m_tdata[ECNT_W +: VAL_W];
            got.last        = m_tlast;
            board.check_result(got);
            if ($urandom_range(39, 0) == 0)
                recv_burst = !recv_burst;
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        board      = new();
        send_burst = 1'b0;
        recv_burst = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_INSERT;
        m_tready   = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // empty list: dump, erase and an insert past the end are all refused
        send_command(CMD_DUMP,   7'd0,   '0);
        send_command(CMD_ERASE,  7'd0,   '0);
        send_command(CMD_INSERT, 7'd1,   32'sd7);
        send_command(CMD_NOP,    7'd127, '1);
        // push front, push back, middle insert, extreme values
        send_command(CMD_INSERT, 7'd0,   32'sh7fffffff);
        send_command(CMD_INSERT, 7'd0,   32'sh80000000);
        send_command(CMD_INSERT, 7'd2,   32'sd0);
        send_command(CMD_INSERT, 7'd1,   -32'sd1);
        send_command(CMD_INSERT, 7'd127, 32'sd5);
        send_command(CMD_DUMP,   7'd0,   '0);
        // erase at and beyond the count, then pop back, pop front
        send_command(CMD_ERASE,  7'd127, '0);
        send_command(CMD_ERASE,  7'd4,   '0);
        send_command(CMD_ERASE,  7'd3,   '0);
        send_command(CMD_ERASE,  7'd0,   '0);
        send_command(CMD_ERASE,  7'd0,   '0);
        send_command(CMD_INSERT, 7'd1,   32'sh55555555);
        send_command(CMD_INSERT, 7'd1,   32'shaaaaaaaa);
        send_command(CMD_DUMP,   7'd0,   '1);
        send_command(CMD_NOP,    7'd0,   '0);
        send_command(CMD_ERASE,  7'd0,   '0);
        send_command(CMD_ERASE,  7'd0,   '0);
        send_command(CMD_ERASE,  7'd0,   '0);
        send_command(CMD_DUMP,   7'd0,   '0);

        // grow to capacity, then knock on the full list and dump all of it
        while (board.held_count < CAPACITY)
            random_item(85, 5, 5);
        repeat (3)
            send_command(CMD_INSERT, POS_W'($urandom_range(127, 0)), pick_value());
        send_command(CMD_DUMP, 7'd0, '0);

        // hold the slave side off until every owed result has come back
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);

        // shrink back to empty, then refused erase and empty dump
        while (board.held_count > 0)
            random_item(10, 80, 5);
        send_command(CMD_ERASE, POS_W'($urandom_range(127, 0)), pick_value());
        send_command(CMD_DUMP, 7'd0, '0);

        // mixed traffic
        repeat (70)
            random_item(40, 35, 10);

        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
